// ===== src/rpn_stack_evaluator_core_assert.svh =====
// Assertion macros used by the evaluator core.
`ifndef RPN_STACK_EVALUATOR_CORE_ASSERT_SVH
`define RPN_STACK_EVALUATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rse_pkg.sv =====
`timescale 1ns / 1ps

package rse_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CHAR_W          = 8;
   localparam int VALUE_W         = 64;
   localparam int STATUS_W        = 3;
   localparam int DIGIT_W         = 4;
   localparam int REQ_DATA_W      = 8;
   localparam int RSP_DATA_W      = 72;
   localparam int RSP_PAD_W       = RSP_DATA_W - VALUE_W - STATUS_W;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      TK_SPACE,
      TK_DIGIT,
      TK_ADD,
      TK_SUB,
      TK_MUL,
      TK_DIV,
      TK_BAD
   } token_kind_type;

   typedef struct packed {
      token_kind_type       kind;
      logic [DIGIT_W-1:0]   digit;
      logic                 last;
   } token_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BAD_CHAR = 3'd1,
      ST_FEW_OPS  = 3'd2,
      ST_DIV_ZERO = 3'd3,
      ST_NOT_ONE  = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } md_op_type;

   typedef struct packed {
      logic      start;
      md_op_type op;
   } md_ctrl_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] result;
   } md_resp_type;

endpackage

// ===== src/rpn_stack_evaluator_core.sv =====
// A kept word passes through the front register and the token queue before it reaches the evaluator.
// Per word: a digit is pushed at once, + or - reads the entry below the top, * uses a
// shared 32-bit multiplier, / a radix-2 divider (one quotient bit a cycle); last adds a finish step.
// The front accepts a word per cycle unless its register holds a word and the four-entry token queue is full.
// Reset is synchronous and leaves the stack empty with no error; no clearing pass.
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_core_assert.svh"

module rpn_stack_evaluator_core #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rse_pkg::REQ_DATA_W-1:0]   req_tdata,  // char_code[7:0]
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rse_pkg::RSP_DATA_W-1:0]   rsp_tdata   // value[63:0], status[66:64]
);
   import rse_pkg::*;

   logic               tok_valid;
   token_type          tok;
   logic               tok_ready;
   logic               q_valid;
   token_type          q_tok;
   logic               q_pop;
   md_ctrl_type        md_ctrl;
   md_resp_type        md_resp;
   logic [VALUE_W-1:0] md_lhs;
   logic [VALUE_W-1:0] md_rhs;
   logic [VALUE_W-1:0] rsp_value;
   status_type         rsp_status;

   rse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .char_code  (req_tdata[CHAR_W-1:0]),
      .last       (req_tlast),
      .tok_valid  (tok_valid),
      .tok        (tok),
      .tok_ready  (tok_ready)
   );

   rse_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (tok_valid),
      .push_tok   (tok),
      .push_ready (tok_ready),
      .pop_valid  (q_valid),
      .pop_tok    (q_tok),
      .pop        (q_pop)
   );

   rse_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .ctrl  (md_ctrl),
      .lhs   (md_lhs),
      .rhs   (md_rhs),
      .resp  (md_resp)
   );

   rse_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_tok      (q_tok),
      .q_pop      (q_pop),
      .md_ctrl    (md_ctrl),
      .md_lhs     (md_lhs),
      .md_rhs     (md_rhs),
      .md_resp    (md_resp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_status, rsp_value};

   `RSE_ASSERT_SAME(a_err_value_zero, clock, reset,
                    rsp_tvalid && (rsp_status != ST_OK), rsp_value == '0,
                    "error result carries a nonzero value")

   `RSE_ASSERT_NEXT(a_front_keeps_word, clock, reset,
                    req_tvalid && req_tready &&
                    (req_tlast || (req_tdata[CHAR_W-1:0] != CH_SPACE)),
                    tok_valid, "accepted word lost in front stage")

   `RSE_ASSERT_NEXT(a_muldiv_not_instant, clock, reset, md_ctrl.start, !md_resp.done,
                    "arithmetic unit finished in the cycle after start")

endmodule

// ===== src/rse_front.sv =====
`timescale 1ns / 1ps

module rse_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [rse_pkg::CHAR_W-1:0]   char_code,
   input  logic                         last,
   output logic                         tok_valid,
   output rse_pkg::token_type           tok,
   input  logic                         tok_ready
);
   import rse_pkg::*;

   logic      tok_valid_ff;
   logic      tok_valid_in;
   token_type tok_ff;
   token_type tok_in;
   token_type cls;
   logic      accept;
   logic      keep;

   always_comb begin
      cls.last  = last;
      cls.digit = DIGIT_W'(char_code - CH_ZERO);
      if (char_code == CH_SPACE) begin
         cls.kind = TK_SPACE;
      end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
         cls.kind = TK_DIGIT;
      end else if (char_code == CH_PLUS) begin
         cls.kind = TK_ADD;
      end else if (char_code == CH_MINUS) begin
         cls.kind = TK_SUB;
      end else if (char_code == CH_STAR) begin
         cls.kind = TK_MUL;
      end else if (char_code == CH_SLASH) begin
         cls.kind = TK_DIV;
      end else begin
         cls.kind = TK_BAD;
      end
   end

   assign req_tready = !tok_valid_ff || tok_ready;
   assign accept     = req_tvalid && req_tready;

   // A space that does not end the expression has no effect and is dropped here.
   assign keep = (cls.kind != TK_SPACE) || last;

   always_comb begin
      tok_valid_in = tok_valid_ff;
      tok_in       = tok_ff;
      if (tok_ready) begin
         tok_valid_in = 1'b0;
      end
      if (accept) begin
         tok_valid_in = keep;
         tok_in       = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
      tok_ff <= tok_in;
   end

   assign tok_valid = tok_valid_ff;
   assign tok       = tok_ff;

endmodule

// ===== src/rse_fifo.sv =====
`timescale 1ns / 1ps

module rse_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  rse_pkg::token_type push_tok,
   output logic               push_ready,
   output logic               pop_valid,
   output rse_pkg::token_type pop_tok,
   input  logic               pop
);
   import rse_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   token_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    fill_ff;
   logic [CW-1:0]    fill_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = fill_ff != CW'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_tok    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

// ===== src/rse_muldiv.sv =====
`timescale 1ns / 1ps

module rse_muldiv (
   input  logic                          clock,
   input  logic                          reset,
   input  rse_pkg::md_ctrl_type          ctrl,
   input  logic [rse_pkg::VALUE_W-1:0]   lhs,
   input  logic [rse_pkg::VALUE_W-1:0]   rhs,
   output rse_pkg::md_resp_type          resp
);
   import rse_pkg::*;

   localparam int HALF_W = VALUE_W / 2;
   localparam int IW     = $clog2(VALUE_W);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_FIX
   } md_state_type;

   md_state_type        state_ff;
   md_state_type        state_in;
   logic [VALUE_W-1:0]  a_ff;
   logic [VALUE_W-1:0]  a_in;
   logic [VALUE_W-1:0]  b_ff;
   logic [VALUE_W-1:0]  b_in;
   logic [VALUE_W-1:0]  acc_ff;
   logic [VALUE_W-1:0]  acc_in;
   logic [VALUE_W-1:0]  prod_ff;
   logic [VALUE_W-1:0]  prod_in;
   logic [1:0]          step_ff;
   logic [1:0]          step_in;
   logic [IW-1:0]       iter_ff;
   logic [IW-1:0]       iter_in;
   logic                neg_ff;
   logic                neg_in;
   md_resp_type         resp_ff;
   md_resp_type         resp_in;
   logic [HALF_W-1:0]   mul_x;
   logic [HALF_W-1:0]   mul_y;
   logic [VALUE_W-1:0]  rem_sh;
   logic [VALUE_W:0]    diff;

   function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] v);
      return v[VALUE_W-1] ? -v : v;
   endfunction

   // The low word of the product is built from three half-width products.
   assign mul_x   = (step_ff == 2'd2) ? a_ff[VALUE_W-1:HALF_W] : a_ff[HALF_W-1:0];
   assign mul_y   = (step_ff == 2'd1) ? b_ff[VALUE_W-1:HALF_W] : b_ff[HALF_W-1:0];
   assign prod_in = mul_x * mul_y;

   // The remainder stays below the divisor magnitude, so its top bit is always clear.
   assign rem_sh = {acc_ff[VALUE_W-2:0], a_ff[VALUE_W-1]};
   assign diff   = {1'b0, rem_sh} - {1'b0, b_ff};

   always_comb begin
      state_in       = state_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      iter_in        = iter_ff;
      neg_in         = neg_ff;
      resp_in.done   = 1'b0;
      resp_in.result = resp_ff.result;
      unique case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               step_in = 2'd0;
               iter_in = '0;
               acc_in  = '0;
               neg_in  = lhs[VALUE_W-1] ^ rhs[VALUE_W-1];
               if (ctrl.op == OP_MUL) begin
                  a_in     = lhs;
                  b_in     = rhs;
                  state_in = S_MUL;
               end else begin
                  a_in     = magnitude(lhs);
                  b_in     = magnitude(rhs);
                  state_in = S_DIV;
               end
            end
         end
         S_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd1) begin
               acc_in = prod_ff;
            end else if (step_ff != 2'd0) begin
               acc_in = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            if (step_ff == 2'd3) begin
               resp_in.done   = 1'b1;
               resp_in.result = acc_in;
               state_in       = S_IDLE;
            end
         end
         S_DIV: begin
            acc_in  = diff[VALUE_W] ? rem_sh : diff[VALUE_W-1:0];
            a_in    = {a_ff[VALUE_W-2:0], !diff[VALUE_W]};
            iter_in = iter_ff + IW'(1);
            if (iter_ff == IW'(VALUE_W - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            resp_in.done   = 1'b1;
            resp_in.result = neg_ff ? -a_ff : a_ff;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         resp_ff.done <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resp_ff.done <= resp_in.done;
      end
      resp_ff.result <= resp_in.result;
      a_ff           <= a_in;
      b_ff           <= b_in;
      acc_ff         <= acc_in;
      prod_ff        <= prod_in;
      step_ff        <= step_in;
      iter_ff        <= iter_in;
      neg_ff         <= neg_in;
   end

   assign resp = resp_ff;

endmodule

// ===== src/rse_back.sv =====
`timescale 1ns / 1ps

module rse_back #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  rse_pkg::token_type            q_tok,
   output logic                          q_pop,
   output rse_pkg::md_ctrl_type          md_ctrl,
   output logic [rse_pkg::VALUE_W-1:0]   md_lhs,
   output logic [rse_pkg::VALUE_W-1:0]   md_rhs,
   input  rse_pkg::md_resp_type          md_resp,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rse_pkg::VALUE_W-1:0]   rsp_value,
   output rse_pkg::status_type           rsp_status
);
   import rse_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_WAIT,
      BK_FINISH
   } back_state_type;

   back_state_type      state_ff;
   back_state_type      state_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   status_type          err_ff;
   status_type          err_in;
   logic [VALUE_W-1:0]  tos_ff;
   logic [VALUE_W-1:0]  tos_in;
   token_type           cur_ff;
   token_type           cur_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [VALUE_W-1:0]  value_ff;
   logic [VALUE_W-1:0]  value_in;
   status_type          status_ff;
   status_type          status_in;
   logic [VALUE_W-1:0]  stack_mem [STACK_DEPTH];
   logic [VALUE_W-1:0]  rd_data_ff;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic                op_done;
   logic                go_read;
   status_type          final_status;

   // The top of the stack lives in a register; the memory holds the entries below it.
   assign wr_addr = AW'(count_ff - CW'(1));
   assign rd_addr = AW'(count_ff - CW'(2));
   assign q_pop   = (state_ff == BK_IDLE) && q_valid;
   assign md_lhs  = rd_data_ff;
   assign md_rhs  = tos_ff;

   always_comb begin
      if (err_ff != ST_OK) begin
         final_status = err_ff;
      end else if (count_ff != CW'(1)) begin
         final_status = ST_NOT_ONE;
      end else begin
         final_status = ST_OK;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      tos_in        = tos_ff;
      cur_in        = cur_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      wr_en         = 1'b0;
      op_done       = 1'b0;
      go_read       = 1'b0;
      md_ctrl.start = 1'b0;
      md_ctrl.op    = OP_MUL;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               cur_in = q_tok;
               if (err_ff == ST_OK) begin
                  unique case (q_tok.kind) inside
                     TK_SPACE: begin
                     end
                     TK_DIGIT: begin
                        if (count_ff == CW'(STACK_DEPTH)) begin
                           err_in = ST_OVERFLOW;
                        end else begin
                           wr_en    = count_ff != '0;
                           tos_in   = VALUE_W'(q_tok.digit);
                           count_in = count_ff + CW'(1);
                        end
                     end
                     TK_ADD, TK_SUB, TK_MUL, TK_DIV: begin
                        if (count_ff < CW'(2)) begin
                           err_in = ST_FEW_OPS;
                        end else begin
                           go_read = 1'b1;
                        end
                     end
                     default: begin
                        err_in = ST_BAD_CHAR;
                     end
                  endcase
               end
               if (go_read) begin
                  state_in = BK_READ;
               end else if (q_tok.last) begin
                  state_in = BK_FINISH;
               end
            end
         end
         BK_READ: begin
            unique case (cur_ff.kind)
               TK_ADD: begin
                  tos_in   = rd_data_ff + tos_ff;
                  count_in = count_ff - CW'(1);
                  op_done  = 1'b1;
               end
               TK_SUB: begin
                  tos_in   = rd_data_ff - tos_ff;
                  count_in = count_ff - CW'(1);
                  op_done  = 1'b1;
               end
               TK_MUL: begin
                  md_ctrl.start = 1'b1;
                  md_ctrl.op    = OP_MUL;
                  state_in      = BK_WAIT;
               end
               TK_DIV: begin
                  if (tos_ff == '0) begin
                     err_in  = ST_DIV_ZERO;
                     op_done = 1'b1;
                  end else begin
                     md_ctrl.start = 1'b1;
                     md_ctrl.op    = OP_DIV;
                     state_in      = BK_WAIT;
                  end
               end
               default: begin
                  op_done = 1'b1;
               end
            endcase
         end
         BK_WAIT: begin
            if (md_resp.done) begin
               tos_in   = md_resp.result;
               count_in = count_ff - CW'(1);
               op_done  = 1'b1;
            end
         end
         BK_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               status_in    = final_status;
               value_in     = (final_status == ST_OK) ? tos_ff : '0;
               count_in     = '0;
               err_in       = ST_OK;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      if (op_done) begin
         state_in = cur_ff.last ? BK_FINISH : BK_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tos_ff    <= tos_in;
      cur_ff    <= cur_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= tos_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

endmodule
